>>> hw/rtl/pse_pkg.sv
// Shared types and constants of the polyline stroke expander.
`default_nettype none
package pse_pkg;

  // Register indexes of the configuration port
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COLOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOSED_LOOP  = 2'd2;

  localparam int REG_W = 32;

  // Normaliser: the larger magnitude is brought to this top bit
  localparam int NORM_TOP   = 29;
  // One result bit per square-root step
  localparam int ROOT_STEPS = 32;

  // Normaliser handshake
  typedef struct packed {
    logic start;
  } pse_norm_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } pse_norm_stat_t;

endpackage
`default_nettype wire

>>> hw/rtl/polyline_stroke_expander.sv
// Top level of the polyline stroke expander with bevel joins.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------------------
//  point in | in_valid_i / in_ready_o   | point_x_i, point_y_i, last_point_i
//  vertex   | out_valid_o / out_ready_i | vertex_x_o, vertex_y_o, color_out_o,
//           |                           | last_vertex_o
//  config   | cfg_we_i                  | cfg_idx_i, cfg_data_i
//
// The first point of a polyline is only stored. Each later point runs one or two
// normalisations on the shared unit, each a shift search, the squares of both magnitudes,
// 32 root steps, two divisions and a done step; then the offset multiplier steps (OFFX,
// OFFY, OFFR) and the two output words (EPLUS, EMINUS) of each pair.
// Reset clears the sequencer and sets the registers to their reset values.
// A stalled output holds the sequencer in its emit step; no point is taken meanwhile.
`default_nettype none
module polyline_stroke_expander
  import pse_pkg::*;
#(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic signed [COORD_BITS-1:0] point_x_i,
  input  wire logic signed [COORD_BITS-1:0] point_y_i,
  input  wire logic                         last_point_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic signed [COORD_BITS-1:0]      vertex_x_o,
  output logic signed [COORD_BITS-1:0]      vertex_y_o,
  output logic [REG_W-1:0]                  color_out_o,
  output logic                              last_vertex_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]         cfg_idx_i,
  input  wire logic [REG_W-1:0]             cfg_data_i
);

  localparam int C  = COORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int DW = (C + 1 > F + 3) ? C + 1 : F + 3;
  localparam int UW = F + 2;
  localparam int MW = F + 1;
  localparam int PW = MW + REG_W;
  localparam int SW = ((C > REG_W) ? C : REG_W) + 2;
  localparam logic signed [SW-1:0] SMAX = (SW'(1) <<< (C - 1)) - SW'(1);
  localparam logic signed [SW-1:0] SMIN = -SMAX - SW'(1);
  localparam logic [PW:0] OFF_CAP = (PW + 1)'(32'h7FFF_FFFF);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SEGW   = 3'd1;
  localparam logic [2:0] S_JW     = 3'd2;
  localparam logic [2:0] S_OFFX   = 3'd3;
  localparam logic [2:0] S_OFFY   = 3'd4;
  localparam logic [2:0] S_OFFR   = 3'd5;
  localparam logic [2:0] S_EPLUS  = 3'd6;
  localparam logic [2:0] S_EMINUS = 3'd7;

  localparam logic [1:0] PH_PREV  = 2'd0;
  localparam logic [1:0] PH_LAST  = 2'd1;
  localparam logic [1:0] PH_CLOSE = 2'd2;

  // Registers and sequencer
  logic [REG_W-1:0]       width_q, color_q;
  logic                   closed_q;
  logic [2:0]             state_q, state_d;
  logic [1:0]             count_q, count_d, phase_q, phase_d;
  logic                   last_q, last_d;
  logic signed [C-1:0]    px_q, px_d, py_q, py_d;
  logic signed [C-1:0]    prevx_q, prevx_d, prevy_q, prevy_d;
  logic signed [C-1:0]    firstx_q, firstx_d, firsty_q, firsty_d;
  logic signed [UW-1:0]   nx_q, nx_d, ny_q, ny_d, pnx_q, pnx_d, pny_q, pny_d;
  logic signed [UW-1:0]   vx_q, vx_d, vy_q, vy_d;
  logic [PW-1:0]          prod_q, prod_d;
  logic signed [REG_W-1:0] offx_q, offx_d, offy_q, offy_d;
  logic signed [REG_W-1:0] foffx_q, foffx_d, foffy_q, foffy_d;
  logic                   ov_q, ov_d, olast_q, olast_d;
  logic signed [C-1:0]    ox_q, ox_d, oy_q, oy_d;
  logic [REG_W-1:0]       ocol_q, ocol_d;

  pse_norm_ctrl_t         nctrl;
  pse_norm_stat_t         nstat;
  logic signed [DW-1:0]   nvec_x, nvec_y;
  logic signed [UW-1:0]   ux, uy, seg_nx, seg_ny;

  logic signed [UW-1:0]   mul_v;
  logic [MW-1:0]          mul_mag;
  logic [PW-1:0]          mul_p;
  logic [PW:0]            rnd;
  logic [REG_W-1:0]       rmag;
  logic signed [REG_W-1:0] roff;
  logic signed [C-1:0]    ptx, pty;
  logic signed [SW-1:0]   sumx, sumy;
  logic                   out_free, in_acc;

  function automatic logic signed [C-1:0] sat_c(input logic signed [SW-1:0] v);
    if (v > SMAX) begin
      return SMAX[C-1:0];
    end else if (v < SMIN) begin
      return SMIN[C-1:0];
    end
    return v[C-1:0];
  endfunction

  // Shared normaliser
  pse_norm #(
    .DW        (DW),
    .FRAC_BITS (F)
  ) u_norm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (nctrl),
    .vec_x_i  (nvec_x),
    .vec_y_i  (nvec_y),
    .stat_o   (nstat),
    .unit_x_o (ux),
    .unit_y_o (uy)
  );

  assign seg_nx = -uy;
  assign seg_ny = ux;

  // Offset multiplier and rounding
  assign mul_v   = (state_q == S_OFFX) ? vx_q : vy_q;
  assign mul_mag = mul_v[UW-1] ? MW'(-mul_v) : MW'(mul_v);
  assign mul_p   = PW'(mul_mag) * PW'(width_q);
  assign rnd     = ({1'b0, prod_q} + ((PW + 1)'(1) << F)) >> (F + 1);
  assign rmag    = (rnd > OFF_CAP) ? 32'h7FFF_FFFF : rnd[REG_W-1:0];
  assign roff    = ((state_q == S_OFFY) ? vx_q[UW-1] : vy_q[UW-1]) ?
                   -$signed(rmag) : $signed(rmag);

  // Vertex adder
  always_comb begin
    case (phase_q)
      PH_LAST: begin
        ptx = px_q;  pty = py_q;
      end
      PH_CLOSE: begin
        ptx = firstx_q;  pty = firsty_q;
      end
      default: begin
        ptx = prevx_q;  pty = prevy_q;
      end
    endcase
  end
  assign sumx = (state_q == S_EPLUS) ? SW'(ptx) + SW'(offx_q) : SW'(ptx) - SW'(offx_q);
  assign sumy = (state_q == S_EPLUS) ? SW'(pty) + SW'(offy_q) : SW'(pty) - SW'(offy_q);

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !ov_q || out_ready_i;

  always_comb begin
    state_d = state_q;  count_d = count_q;  phase_d = phase_q;  last_d = last_q;
    px_d = px_q;  py_d = py_q;  prevx_d = prevx_q;  prevy_d = prevy_q;
    firstx_d = firstx_q;  firsty_d = firsty_q;
    nx_d = nx_q;  ny_d = ny_q;  pnx_d = pnx_q;  pny_d = pny_q;
    vx_d = vx_q;  vy_d = vy_q;  prod_d = prod_q;
    offx_d = offx_q;  offy_d = offy_q;  foffx_d = foffx_q;  foffy_d = foffy_q;
    ov_d = ov_q && !out_ready_i;
    ox_d = ox_q;  oy_d = oy_q;  ocol_d = ocol_q;  olast_d = olast_q;
    nctrl.start = 1'b0;
    nvec_x = DW'(point_x_i) - DW'(prevx_q);
    nvec_y = DW'(point_y_i) - DW'(prevy_q);
    case (state_q)
      // Take a point; the first of a polyline is only stored
      S_IDLE: begin
        if (in_acc) begin
          px_d   = point_x_i;
          py_d   = point_y_i;
          last_d = last_point_i;
          if (count_q == 2'd0) begin
            firstx_d = point_x_i;  firsty_d = point_y_i;
            prevx_d  = point_x_i;  prevy_d  = point_y_i;
            count_d  = last_point_i ? 2'd0 : 2'd1;
          end else begin
            nctrl.start = 1'b1;
            state_d     = S_SEGW;
          end
        end
      end
      // Segment normal ready; start the join sum for inner points
      S_SEGW: begin
        nvec_x = DW'(pnx_q) + DW'(seg_nx);
        nvec_y = DW'(pny_q) + DW'(seg_ny);
        if (nstat.done) begin
          nx_d    = seg_nx;
          ny_d    = seg_ny;
          phase_d = PH_PREV;
          if (count_q == 2'd1) begin
            vx_d    = seg_nx;
            vy_d    = seg_ny;
            state_d = S_OFFX;
          end else begin
            nctrl.start = 1'b1;
            state_d     = S_JW;
          end
        end
      end
      S_JW: begin
        if (nstat.done) begin
          vx_d    = ux;
          vy_d    = uy;
          state_d = S_OFFX;
        end
      end
      S_OFFX: begin
        prod_d  = mul_p;
        state_d = S_OFFY;
      end
      S_OFFY: begin
        offx_d  = roff;
        prod_d  = mul_p;
        state_d = S_OFFR;
      end
      S_OFFR: begin
        offy_d  = roff;
        state_d = S_EPLUS;
      end
      S_EPLUS: begin
        if (out_free) begin
          ov_d    = 1'b1;
          ox_d    = sat_c(sumx);
          oy_d    = sat_c(sumy);
          ocol_d  = color_q;
          olast_d = 1'b0;
          state_d = S_EMINUS;
        end
      end
      // Second word of the pair; pick the next pair or finish the point
      S_EMINUS: begin
        if (out_free) begin
          ov_d    = 1'b1;
          ox_d    = sat_c(sumx);
          oy_d    = sat_c(sumy);
          ocol_d  = color_q;
          olast_d = (phase_q == PH_CLOSE) || (phase_q == PH_LAST && !closed_q);
          state_d = S_IDLE;
          case (phase_q)
            PH_PREV: begin
              if (count_q == 2'd1) begin
                foffx_d = offx_q;
                foffy_d = offy_q;
              end
              if (last_q) begin
                vx_d    = nx_q;
                vy_d    = ny_q;
                phase_d = PH_LAST;
                state_d = S_OFFX;
              end else begin
                prevx_d = px_q;  prevy_d = py_q;
                pnx_d   = nx_q;  pny_d   = ny_q;
                count_d = 2'd2;
              end
            end
            PH_LAST: begin
              if (closed_q) begin
                offx_d  = foffx_q;
                offy_d  = foffy_q;
                phase_d = PH_CLOSE;
                state_d = S_EPLUS;
              end else begin
                count_d = 2'd0;
              end
            end
            default: begin
              count_d = 2'd0;
            end
          endcase
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold control state under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= 2'd0;
      ov_q     <= 1'b0;
      width_q  <= 32'h0001_0000;
      color_q  <= 32'hFFFF_FFFF;
      closed_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ov_q    <= ov_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_LINE_WIDTH:   width_q  <= cfg_data_i;
          CFG_VERTEX_COLOR: color_q  <= cfg_data_i;
          CFG_CLOSED_LOOP:  closed_q <= cfg_data_i[0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    phase_q <= phase_d;  last_q <= last_d;
    px_q <= px_d;  py_q <= py_d;  prevx_q <= prevx_d;  prevy_q <= prevy_d;
    firstx_q <= firstx_d;  firsty_q <= firsty_d;
    nx_q <= nx_d;  ny_q <= ny_d;  pnx_q <= pnx_d;  pny_q <= pny_d;
    vx_q <= vx_d;  vy_q <= vy_d;  prod_q <= prod_d;
    offx_q <= offx_d;  offy_q <= offy_d;  foffx_q <= foffx_d;  foffy_q <= foffy_d;
    ox_q <= ox_d;  oy_q <= oy_d;  ocol_q <= ocol_d;  olast_q <= olast_d;
  end

  assign out_valid_o   = ov_q;
  assign vertex_x_o    = ox_q;
  assign vertex_y_o    = oy_q;
  assign color_out_o   = ocol_q;
  assign last_vertex_o = olast_q;

`ifndef ASSERT_OFF
  a_ready_norm_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !nstat.busy)
    else $error("point taken while normaliser busy");
  a_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nstat.done |-> (state_q == S_SEGW || state_q == S_JW))
    else $error("normaliser result not awaited");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("point count out of range");
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nctrl.start |-> !nstat.busy || nstat.done)
    else $error("normaliser started while busy");
`endif

endmodule
`default_nettype wire

>>> hw/rtl/pse_norm.sv
// Iterative vector normaliser: shift search, squares, integer root, division.
`default_nettype none
module pse_norm
  import pse_pkg::*;
#(
  parameter int DW        = 33,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire pse_norm_ctrl_t            ctrl_i,
  input  wire logic signed [DW-1:0]      vec_x_i,
  input  wire logic signed [DW-1:0]      vec_y_i,
  output pse_norm_stat_t                 stat_o,
  output logic signed [FRAC_BITS+1:0]    unit_x_o,
  output logic signed [FRAC_BITS+1:0]    unit_y_o
);

  localparam int F   = FRAC_BITS;
  localparam int NW  = (DW > NORM_TOP + 2) ? DW : NORM_TOP + 2;
  localparam int AW  = NORM_TOP + 1;
  localparam int RW  = 2 * ROOT_STEPS;
  localparam int LW  = AW + 1;
  localparam int QW  = F + 1;
  localparam int UW  = F + 2;
  localparam int DNW = AW + F + 1;
  localparam int CW  = $clog2(ROOT_STEPS);

  localparam logic [3:0] N_IDLE  = 4'd0;
  localparam logic [3:0] N_SHIFT = 4'd1;
  localparam logic [3:0] N_SQX   = 4'd2;
  localparam logic [3:0] N_SQY   = 4'd3;
  localparam logic [3:0] N_ROOT  = 4'd4;
  localparam logic [3:0] N_DSET  = 4'd5;
  localparam logic [3:0] N_DIV   = 4'd6;
  localparam logic [3:0] N_DONE  = 4'd7;

  logic [3:0]           state_q, state_d;
  logic [NW-1:0]        ax_q, ax_d, ay_q, ay_d;
  logic                 negx_q, negx_d, negy_q, negy_d;
  logic [RW-1:0]        n_q, n_d, res_q, res_d, bit_q, bit_d;
  logic [2*AW-1:0]      sq_q, sq_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [LW-1:0]        len_q, len_d, rem_q, rem_d;
  logic [QW-1:0]        lo_q, lo_d, quo_q, quo_d;
  logic                 comp_q, comp_d;
  logic signed [UW-1:0] ux_q, ux_d, uy_q, uy_d;

  logic [DW-1:0]        magx, magy;
  logic [NW-1:0]        mmax;
  logic [AW-1:0]        sq_op;
  logic [2*AW-1:0]      sqr;
  logic [RW-1:0]        rt;
  logic [DNW-1:0]       num;
  logic [LW:0]          dt;
  logic                 ge;
  logic [QW-1:0]        qcap;
  logic signed [UW-1:0] uval;

  assign magx  = vec_x_i[DW-1] ? DW'(-vec_x_i) : DW'(vec_x_i);
  assign magy  = vec_y_i[DW-1] ? DW'(-vec_y_i) : DW'(vec_y_i);
  assign mmax  = (ax_q > ay_q) ? ax_q : ay_q;
  // Shared squarer
  assign sq_op = (state_q == N_SQY) ? ay_q[AW-1:0] : ax_q[AW-1:0];
  assign sqr   = sq_op * sq_op;
  assign rt    = res_q + bit_q;
  assign num   = (DNW'(comp_q ? ay_q[AW-1:0] : ax_q[AW-1:0]) << F) + DNW'(len_q >> 1);
  assign dt    = {rem_q, lo_q[QW-1]};
  assign ge    = dt >= {1'b0, len_q};
  assign qcap  = (quo_d > (QW'(1) << F)) ? (QW'(1) << F) : quo_d;
  assign uval  = (comp_q ? negy_q : negx_q) ? -$signed({1'b0, qcap}) : $signed({1'b0, qcap});

  always_comb begin
    state_d = state_q;
    ax_d = ax_q;  ay_d = ay_q;  negx_d = negx_q;  negy_d = negy_q;
    n_d = n_q;  res_d = res_q;  bit_d = bit_q;  sq_d = sq_q;
    cnt_d = cnt_q;  len_d = len_q;  rem_d = rem_q;  lo_d = lo_q;
    quo_d = quo_q;  comp_d = comp_q;  ux_d = ux_q;  uy_d = uy_q;
    case (state_q)
      // Take a new vector; the done cycle takes one as well
      N_IDLE, N_DONE: begin
        if (state_q == N_DONE) begin
          state_d = N_IDLE;
        end
        if (ctrl_i.start) begin
          ax_d   = NW'(magx);
          ay_d   = NW'(magy);
          negx_d = vec_x_i[DW-1];
          negy_d = vec_y_i[DW-1];
          comp_d = 1'b0;
          if (magx == '0 && magy == '0) begin
            ux_d    = '0;
            uy_d    = '0;
            state_d = N_DONE;
          end else begin
            state_d = N_SHIFT;
          end
        end
      end
      // Bring the larger magnitude to the top bit, one place a cycle
      N_SHIFT: begin
        if ((mmax >> AW) != '0) begin
          ax_d = ax_q >> 1;
          ay_d = ay_q >> 1;
        end else if (!mmax[AW-1]) begin
          ax_d = ax_q << 1;
          ay_d = ay_q << 1;
        end else begin
          state_d = N_SQX;
        end
      end
      N_SQX: begin
        sq_d    = sqr;
        state_d = N_SQY;
      end
      N_SQY: begin
        n_d     = RW'(sq_q) + RW'(sqr);
        res_d   = '0;
        bit_d   = RW'(1) << (RW - 2);
        cnt_d   = '0;
        state_d = N_ROOT;
      end
      // Integer square root, one result bit a step
      N_ROOT: begin
        if (n_q >= rt) begin
          n_d   = n_q - rt;
          res_d = (res_q >> 1) + bit_q;
        end else begin
          res_d = res_q >> 1;
        end
        bit_d = bit_q >> 2;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CW'(ROOT_STEPS - 1)) begin
          len_d   = res_d[LW-1:0];
          state_d = N_DSET;
        end
      end
      N_DSET: begin
        rem_d   = LW'(num >> (F + 1));
        lo_d    = num[QW-1:0];
        quo_d   = '0;
        cnt_d   = '0;
        state_d = N_DIV;
      end
      // Restoring division, one quotient bit a step
      N_DIV: begin
        rem_d = ge ? LW'(dt - {1'b0, len_q}) : dt[LW-1:0];
        lo_d  = lo_q << 1;
        quo_d = {quo_q[QW-2:0], ge};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CW'(QW - 1)) begin
          if (comp_q) begin
            uy_d    = uval;
            state_d = N_DONE;
          end else begin
            ux_d    = uval;
            comp_d  = 1'b1;
            state_d = N_DSET;
          end
        end
      end
      default: begin
        state_d = N_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= N_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ax_q <= ax_d;  ay_q <= ay_d;  negx_q <= negx_d;  negy_q <= negy_d;
    n_q <= n_d;  res_q <= res_d;  bit_q <= bit_d;  sq_q <= sq_d;
    cnt_q <= cnt_d;  len_q <= len_d;  rem_q <= rem_d;  lo_q <= lo_d;
    quo_q <= quo_d;  comp_q <= comp_d;  ux_q <= ux_d;  uy_q <= uy_d;
  end

  assign stat_o.busy = (state_q != N_IDLE);
  assign stat_o.done = (state_q == N_DONE);
  assign unit_x_o    = ux_q;
  assign unit_y_o    = uy_q;

endmodule
`default_nettype wire

>>> dv/polyline_stroke_expander_tb.sv
// Self-checking testbench of the polyline stroke expander, with a scoreboard that predicts vertices.
`timescale 1ns / 100ps
module polyline_stroke_expander_tb;
  import pse_pkg::*;

  localparam int CW = 32;
  localparam int FB = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 400;
  localparam int STALL_LIMIT  = 20000;

  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic [REG_W-1:0]     color;
    logic                 last;
  } vertex_t;

  // Scoreboard: holds a copy of the expander state and the queue of expected vertices
  class stroke_scoreboard;
    logic [REG_W-1:0] width_q, color_q;
    logic             loop_q;
    int               npts;
    longint           first_x, first_y, prev_x, prev_y, first_ox, first_oy, pnx, pny;
    vertex_t          pending[$];
    int               errors;

    function new();
      width_q = 32'd65536; color_q = 32'hFFFF_FFFF; loop_q = 1'b0; errors = 0;
      clear();
    endfunction

    function void clear();
      npts = 0; first_x = 0; first_y = 0; prev_x = 0; prev_y = 0;
      first_ox = 0; first_oy = 0; pnx = 0; pny = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] d);
      case (idx)
        CFG_LINE_WIDTH:   width_q = d;
        CFG_VERTEX_COLOR: color_q = d;
        CFG_CLOSED_LOOP:  loop_q = d[0];
        default: ;
      endcase
    endfunction

    function longint unsigned mag(longint v);
      return v < 0 ? -v : v;
    endfunction

    function longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res, b;
      res = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= res + b) begin
          n -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    function longint unit_part(longint unsigned a, bit neg, longint unsigned len);
      longint unsigned q;
      q = ((a << FB) + (len >> 1)) / len;
      if (q > (64'd1 << FB)) q = 64'd1 << FB;
      return neg ? -longint'(q) : longint'(q);
    endfunction

    // Scale the larger magnitude to the normaliser's top bit, then divide by the root
    function void unit_vec(longint x, longint y, output longint nx, output longint ny);
      longint unsigned ax, ay, m, len;
      int top;
      ax = mag(x); ay = mag(y);
      m = ax > ay ? ax : ay;
      top = 0;
      if (m == 0) begin
        nx = 0; ny = 0;
        return;
      end
      while (top < 63 && (m >> (top + 1)) != 0) top++;
      if (top > NORM_TOP) begin
        ax >>= (top - NORM_TOP); ay >>= (top - NORM_TOP);
      end else begin
        ax <<= (NORM_TOP - top); ay <<= (NORM_TOP - top);
      end
      len = int_sqrt(ax * ax + ay * ay);
      nx = unit_part(ax, x < 0, len);
      ny = unit_part(ay, y < 0, len);
    endfunction

    function longint offset(longint n);
      longint unsigned r;
      r = (mag(n) * longint'(width_q) + (64'd1 << FB)) >> (FB + 1);
      if (r > 64'h7FFF_FFFF) r = 64'h7FFF_FFFF;
      return n < 0 ? -longint'(r) : longint'(r);
    endfunction

    function logic [CW-1:0] clip(longint v);
      if (v > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
      if (v < -64'sh8000_0000) return 32'h8000_0000;
      return v[CW-1:0];
    endfunction

    function void push_pair(longint px, longint py, longint ox, longint oy);
      vertex_t v;
      v.color = color_q; v.last = 1'b0;
      v.x = clip(px + ox); v.y = clip(py + oy);
      pending.insert(pending.size(), v);
      v.x = clip(px - ox); v.y = clip(py - oy);
      pending.insert(pending.size(), v);
    endfunction

    // Note an accepted point and queue the vertices it releases
    function void take_point(logic signed [CW-1:0] x, logic signed [CW-1:0] y, logic lst);
      longint px, py, dx, dy, nx, ny, jx, jy;
      px = x; py = y;
      if (npts == 0) begin
        if (lst) begin
          clear();
          return;
        end
        first_x = px; prev_x = px; first_y = py; prev_y = py;
        npts = 1;
        return;
      end
      unit_vec(px - prev_x, py - prev_y, dx, dy);
      nx = -dy; ny = dx;
      if (npts == 1) begin
        first_ox = offset(nx); first_oy = offset(ny);
        push_pair(prev_x, prev_y, first_ox, first_oy);
      end else begin
        unit_vec(pnx + nx, pny + ny, jx, jy);
        push_pair(prev_x, prev_y, offset(jx), offset(jy));
      end
      if (lst) begin
        push_pair(px, py, offset(nx), offset(ny));
        if (loop_q) push_pair(first_x, first_y, first_ox, first_oy);
        pending[$].last = 1'b1;
        clear();
        return;
      end
      prev_x = px; prev_y = py; pnx = nx; pny = ny;
      npts = 2;
    endfunction

    // Compare a delivered vertex with the oldest expected one
    function void check_vertex(vertex_t got);
      vertex_t exp_v;
      if (pending.size() == 0) begin
        $display("%0t: vertex with none expected: x=%h y=%h", $realtime, got.x, got.y);
        errors++;
        return;
      end
      exp_v = pending.pop_front();
      if (got.x !== exp_v.x) begin
        $display("%0t: vertex_x expected %h actual %h", $realtime, exp_v.x, got.x);
        errors++;
      end
      if (got.y !== exp_v.y) begin
        $display("%0t: vertex_y expected %h actual %h", $realtime, exp_v.y, got.y);
        errors++;
      end
      if (got.color !== exp_v.color) begin
        $display("%0t: color_out expected %h actual %h", $realtime, exp_v.color, got.color);
        errors++;
      end
      if (got.last !== exp_v.last) begin
        $display("%0t: last_vertex expected %b actual %b", $realtime, exp_v.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [CW-1:0] point_x_i = '0;
  logic signed [CW-1:0] point_y_i = '0;
  logic last_point_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [CW-1:0] vertex_x_o, vertex_y_o;
  logic [REG_W-1:0] color_out_o;
  logic last_vertex_o;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [REG_W-1:0] cfg_data_i = '0;

  stroke_scoreboard sb = new();
  bit calm = 1'b0;
  int quiet_cycles = 0;

  polyline_stroke_expander #(.COORD_BITS(CW), .FRAC_BITS(FB)) DUT (.*);

  always #10 clk_i = ~clk_i;

  // Random back-pressure on the vertex side
  always @(posedge clk_i)
    if (rst_ni) out_ready_i <= calm || ($urandom_range(0, 99) >= 14);

  // Monitor accepted words and register writes; watch for a hang
  always @(posedge clk_i) begin
    vertex_t got;
    bit moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (cfg_we_i) sb.write_reg(cfg_idx_i, cfg_data_i);
      if (in_valid_i && in_ready_o) begin
        sb.take_point(point_x_i, point_y_i, last_point_i);
        moved = 1'b1;
      end
      if (out_valid_o && out_ready_i) begin
        got.x = vertex_x_o; got.y = vertex_y_o; got.color = color_out_o;
        got.last = last_vertex_o;
        sb.check_vertex(got);
        moved = 1'b1;
      end
      quiet_cycles <= moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // Offer one point and hold it until accepted; valid stays up into the next point
  task automatic send_point(logic signed [CW-1:0] x, logic signed [CW-1:0] y, logic lst);
    if (!calm && $urandom_range(0, 99) < 14) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    point_x_i <= x; point_y_i <= y; last_point_i <= lst;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
  endtask

  // Drain every expected vertex, then let the block settle
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] d);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= d;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic signed [CW-1:0] rand_coord(bit wide);
    if (wide) return $urandom;
    return $signed($urandom_range(0, 32'h1F_FFFF)) - 32'sh10_0000;
  endfunction

  task automatic send_polyline(int n, bit wide);
    for (int i = 0; i < n; i++) send_point(rand_coord(wide), rand_coord(wide), i == n - 1);
  endtask

  initial begin
    int count;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: defaults, single point, zero-length segment, folded-back path
    send_point(32'sd5 << FB, 32'sd7 << FB, 1'b1);
    send_point(0, 0, 1'b0);
    send_point(0, 0, 1'b1);
    send_point(0, 0, 1'b0);
    send_point(32'sd1 << FB, 0, 1'b0);
    send_point(0, 0, 1'b1);
    send_point(32'sd3 << FB, 32'sd4 << FB, 1'b0);
    send_point(32'sd10 << FB, 32'sd9 << FB, 1'b0);
    send_point(-32'sd2 << FB, 32'sd20 << FB, 1'b1);
    drain();

    // Directed: widest stroke, loop closed, coordinate extremes to hit saturation
    write_reg(CFG_LINE_WIDTH, 32'hFFFF_FFFF);
    write_reg(CFG_VERTEX_COLOR, 32'h0000_0000);
    write_reg(CFG_CLOSED_LOOP, 1'b1);
    write_reg(CFG_UNUSED, 32'h1234_5678);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    send_point(32'sh8000_0000, 32'h7FFF_FFFF, 1'b0);
    send_point(32'sh8000_0000, 32'sh8000_0000, 1'b0);
    send_point(32'h7FFF_FFFF, 32'sh8000_0000, 1'b1);
    send_point(-32'sd1, 32'sd1, 1'b0);
    send_point(32'sd1, -32'sd1, 1'b1);
    drain();

    // Directed: zero width
    write_reg(CFG_LINE_WIDTH, 32'h0);
    write_reg(CFG_VERTEX_COLOR, 32'hA5A5_5A5A);
    send_point(32'sd100, 32'sd200, 1'b0);
    send_point(32'sd300, -32'sd50, 1'b0);
    send_point(32'sd900, 32'sd10, 1'b1);
    drain();

    // Random phases with fresh settings; the last phase runs without idling
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(CFG_LINE_WIDTH, (ph == 2) ? $urandom : $urandom_range(0, 32'h40_0000));
      write_reg(CFG_VERTEX_COLOR, $urandom);
      write_reg(CFG_CLOSED_LOOP, $urandom_range(0, 1));
      calm = (ph == 4);
      count = 0;
      while (count < 56) begin
        int n;
        n = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 6);
        if ($urandom_range(0, 9) == 0) begin
          // Repeated point: zero-length segment inside a polyline
          send_point(32'sd77, -32'sd77, 1'b0);
          send_point(32'sd77, -32'sd77, n == 1);
          count += 2;
          if (n == 1) continue;
        end
        send_polyline(n, $urandom_range(0, 3) == 0);
        count += n;
      end
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/pse_pkg.sv
hw/rtl/pse_norm.sv
hw/rtl/polyline_stroke_expander.sv
dv/polyline_stroke_expander_tb.sv
